@@ design/dvet_pkg.sv @@
// Shared types and constants for the trial-division divisor enumerator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package dvet_pkg;

	localparam int NUM_WIDTH_DEF = 12;
	localparam int NUM_PORT_W    = 12;
	localparam int POS_W         = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_TEST,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load_num;
		logic div_init;
		logic div_step;
		logic emit;
		logic emit_last;
		logic next_cand;
	} cmd_t;

	typedef struct packed {
		logic cand_ge_num;
		logic nxt_done;
		logic bit_zero;
		logic rem_zero;
	} status_t;

endpackage

`default_nettype wire

@@ design/divisor_enumerator_trial_top.sv @@
// Divisor enumerator by trial division, candidates 1 .. N-1, then N itself.
// Each candidate runs through the bit-serial remainder loop (NUM_WIDTH division
// steps plus one test); output stalls hold the item, and one item is in work at a time.
// The next item is taken while the final result still waits in the output register.
// arst_n clears the state machine and output valid; data registers are not reset.
`default_nettype none

module divisor_enumerator_trial_top
	import dvet_pkg::*;
#(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [NUM_PORT_W-1:0] number,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [NUM_PORT_W-1:0] divisor,
	output logic      [POS_W-1:0]      position,
	output logic                       last
);

	cmd_t    cmd;
	status_t status;

	dvet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dvet_datapath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk      (clk),
		.number   (number),
		.cmd      (cmd),
		.status   (status),
		.divisor  (divisor),
		.position (position),
		.last     (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_num, cmd.emit, cmd.emit_last}))
		else $error("conflicting datapath loads");

	a_emit_exact: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.rem_zero)
		else $error("candidate emitted with nonzero remainder");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(cmd.emit || cmd.emit_last))
		else $error("pending result overwritten");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position != '0)
		else $error("result with zero position");

endmodule

`default_nettype wire

@@ design/dvet_datapath.sv @@
// Datapath: number, candidate, bit-serial remainder unit, count and output register.
// Depends on dvet_pkg; driven by dvet_ctrl through cmd_t, reports through status_t.
`default_nettype none

module dvet_datapath
	import dvet_pkg::*;
#(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic [NUM_PORT_W-1:0] number,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	output logic      [NUM_PORT_W-1:0] divisor,
	output logic      [POS_W-1:0]      position,
	output logic                       last
);

	localparam int BIT_W = $clog2(NUM_WIDTH);

	logic [NUM_WIDTH-1:0] num_q;
	logic [NUM_WIDTH-1:0] cand_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [BIT_W-1:0]     bit_q;
	logic [POS_W-1:0]     cnt_q;
	logic [NUM_WIDTH-1:0] div_q;
	logic [POS_W-1:0]     pos_q;
	logic                 last_q;

	logic [NUM_WIDTH:0]   shifted;
	logic [NUM_WIDTH:0]   diff;
	logic [NUM_WIDTH-1:0] rem_next;
	logic [NUM_WIDTH:0]   cand_inc;

	// one restoring-division step: bring down the next bit, subtract if it fits
	always_comb begin
		shifted  = {rem_q, num_q[bit_q]};
		diff     = shifted - {1'b0, cand_q};
		rem_next = (shifted >= {1'b0, cand_q}) ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
		cand_inc = {1'b0, cand_q} + {{NUM_WIDTH{1'b0}}, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			num_q  <= number[NUM_WIDTH-1:0];
			cand_q <= {{(NUM_WIDTH-1){1'b0}}, 1'b1};
			cnt_q  <= '0;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			bit_q <= BIT_W'(NUM_WIDTH - 1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			bit_q <= bit_q - BIT_W'(1);
		end
		if (cmd.next_cand)
			cand_q <= cand_inc[NUM_WIDTH-1:0];
		if (cmd.emit) begin
			div_q  <= cand_q;
			pos_q  <= cnt_q + POS_W'(1);
			last_q <= 1'b0;
			cnt_q  <= cnt_q + POS_W'(1);
		end
		if (cmd.emit_last) begin
			div_q  <= num_q;
			pos_q  <= cnt_q + POS_W'(1);
			last_q <= 1'b1;
		end
	end

	always_comb begin
		status.cand_ge_num = (cand_q >= num_q);
		status.nxt_done    = (cand_inc >= {1'b0, num_q});
		status.bit_zero    = (bit_q == '0);
		status.rem_zero    = (rem_q == '0);
	end

	assign divisor  = NUM_PORT_W'(div_q);
	assign position = pos_q;
	assign last     = last_q;

endmodule

`default_nettype wire

@@ design/dvet_ctrl.sv @@
// Controller state machine: sequences candidates, division steps and result loads.
// Depends on dvet_pkg; owns the input ready and the output valid flag.
`default_nettype none

module dvet_ctrl
	import dvet_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load_out;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_num = 1'b1;
					state_d      = ST_START;
				end
			end
			ST_START: begin
				if (status.cand_ge_num)
					state_d = ST_FINAL;
				else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.bit_zero)
					state_d = ST_TEST;
			end
			ST_TEST: begin
				// a divisor found waits here until the output register is free
				if (!status.rem_zero || out_free) begin
					cmd.emit      = status.rem_zero;
					cmd.next_cand = 1'b1;
					if (status.nxt_done)
						state_d = ST_FINAL;
					else begin
						cmd.div_init = 1'b1;
						state_d      = ST_DIV;
					end
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign load_out  = cmd.emit || cmd.emit_last;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
